// ----- rtl/oust_pkg.sv -----
// Package for the ordered unique set table.
// Holds the command codes, the per-cell broadcast bus and width constants.
// No dependencies.
`default_nettype none

package oust_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned ELEM_WIDTH_DEF = 32;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    OP_ADD      = 3'd0,
    OP_CONTAINS = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_GET      = 3'd3,
    OP_CLEAR    = 3'd4
  } op_e;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic               en;         // item accepted this cycle
    op_e                op;
    logic [INDEX_W-1:0] index;
    logic               found_any;  // some held entry matches the value
  } cell_bus_t;

endpackage

`default_nettype wire

// ----- rtl/oust_cell.sv -----
// One position of the set table: holds an entry and its held flag.
// Compares against the broadcast value, ripples match and read data to the
// next cell, and takes its neighbor's entry when a remove closes the gap.
// Depends on oust_pkg.
`default_nettype none

module oust_cell
  import oust_pkg::*;
#(
  parameter int unsigned ELEM_W = ELEM_WIDTH_DEF,
  parameter int unsigned POS    = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cell_bus_t         bus_i,
  input  wire logic [ELEM_W-1:0] value_i,
  input  wire logic              prev_valid_i,
  input  wire logic              found_i,
  input  wire logic              next_valid_i,
  input  wire logic [ELEM_W-1:0] next_entry_i,
  input  wire logic [ELEM_W-1:0] rd_i,
  output logic                   valid_o,
  output logic [ELEM_W-1:0]      entry_o,
  output logic                   found_o,
  output logic [ELEM_W-1:0]      rd_o
);

  // Positions past the index range can never be read by get.
  localparam bit                 Reach  = (POS < (2 ** INDEX_W));
  localparam logic [INDEX_W-1:0] PosIdx = INDEX_W'(POS % (2 ** INDEX_W));

  logic              valid_q, valid_d;
  logic [ELEM_W-1:0] entry_q, entry_d;
  logic              match;
  logic              hit;
  logic              append;

  always_comb begin
    match   = valid_q && (entry_q == value_i);
    found_o = found_i | match;
    hit     = Reach && valid_q && (bus_i.op == OP_GET) && (bus_i.index == PosIdx);
    rd_o    = rd_i | (hit ? entry_q : '0);
    append  = !bus_i.found_any && !valid_q && prev_valid_i;
  end

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (bus_i.en) begin
      case (bus_i.op)
        OP_ADD: begin
          if (append) begin
            valid_d = 1'b1;
            entry_d = value_i;
          end
        end
        OP_REMOVE: begin
          // match at or before this place: everything here moves down one
          if (found_o) begin
            valid_d = next_valid_i;
            entry_d = next_entry_i;
          end
        end
        OP_CLEAR: valid_d = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ----- rtl/ordered_unique_set_table_unit.sv -----
// Ordered unique set table: insertion-ordered set of unique elements.
// Command items enter on s_axis; tuser carries the command code
// (add, contains, remove, get, clear), tdata the value and get index.
// Every item gives exactly one result item on m_axis: tuser holds ok and
// full_res, tdata the read data and the count held after the command.
// Storage is a row of DEPTH cells; each compares its entry with the value,
// ripples the match and read data on, and on remove takes its upper
// neighbor's entry, so every cell updates at once when a command is taken.
// The result is registered and shows in the cycle after acceptance.
// Throughput: one item per cycle while m_axis_tready is high; the ripple
// of the match flag through the cell row sets the cycle time.
// When the receiver stalls, the result waits in the output register and a
// new item is taken in the cycle the waiting one leaves.
// Reset empties the set (count zero) and clears the output valid flag; entry
// bits stay undefined until written and are never read while not held.
// Depends on oust_pkg and oust_cell.
`default_nettype none

module ordered_unique_set_table_unit
  import oust_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // value[31:0], index[35:32], zero pad
  input  wire logic [2:0]  s_axis_tuser,  // cmd[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // data[31:0], count[36:32], zero pad
  output logic [1:0]       m_axis_tuser   // ok[0], full_res[1]
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  logic                  accept;
  op_e                   op;
  logic [ELEM_WIDTH-1:0] value;
  logic [INDEX_W-1:0]    index;
  cell_bus_t             bus;

  logic [CNT_W-1:0]      count_q, count_d;
  logic                  out_valid_q;
  logic                  ok_q, ok_d;
  logic                  full_q, full_d;
  logic [VALUE_W-1:0]    data_q, data_d;
  logic [COUNT_W-1:0]    count_out_q;

  logic [DEPTH-1:0]                 valid_v;
  logic [DEPTH-1:0]                 found_v;
  logic [DEPTH-1:0][ELEM_WIDTH-1:0] entry_v;
  logic [DEPTH-1:0][ELEM_WIDTH-1:0] rd_v;

  logic found_any;
  logic is_full;
  logic idx_in_range;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign op            = op_e'(s_axis_tuser);
  assign value         = ELEM_WIDTH'(s_axis_tdata[VALUE_W-1:0]);
  assign index         = s_axis_tdata[VALUE_W +: INDEX_W];

  assign found_any    = found_v[DEPTH-1];
  assign is_full      = (count_q == CNT_W'(DEPTH));
  assign idx_in_range = (CMP_W'(index) < CMP_W'(count_q));

  always_comb begin
    bus.en        = accept;
    bus.op        = op;
    bus.index     = index;
    bus.found_any = found_any;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  prev_valid;
    logic                  found_in;
    logic                  next_valid;
    logic [ELEM_WIDTH-1:0] next_entry;
    logic [ELEM_WIDTH-1:0] rd_in;

    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
      assign found_in   = 1'b0;
      assign rd_in      = '0;
    end else begin : g_mid
      assign prev_valid = valid_v[i-1];
      assign found_in   = found_v[i-1];
      assign rd_in      = rd_v[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_entry = '0;
    end else begin : g_inner
      assign next_valid = valid_v[i+1];
      assign next_entry = entry_v[i+1];
    end

    oust_cell #(
      .ELEM_W (ELEM_WIDTH),
      .POS    (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .bus_i        (bus),
      .value_i      (value),
      .prev_valid_i (prev_valid),
      .found_i      (found_in),
      .next_valid_i (next_valid),
      .next_entry_i (next_entry),
      .rd_i         (rd_in),
      .valid_o      (valid_v[i]),
      .entry_o      (entry_v[i]),
      .found_o      (found_v[i]),
      .rd_o         (rd_v[i])
    );
  end

  always_comb begin
    count_d = count_q;
    ok_d    = 1'b0;
    full_d  = 1'b0;
    data_d  = '0;
    case (op)
      OP_ADD: begin
        if (!found_any) begin
          if (is_full) begin
            full_d = 1'b1;
          end else begin
            ok_d    = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      OP_CONTAINS: ok_d = found_any;
      OP_REMOVE: begin
        if (found_any) begin
          ok_d    = 1'b1;
          count_d = count_q - CNT_W'(1);
        end
      end
      OP_GET: begin
        if (idx_in_range) begin
          ok_d   = 1'b1;
          data_d = VALUE_W'(rd_v[DEPTH-1]);
        end
      end
      OP_CLEAR: count_d = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q        <= ok_d;
      full_q      <= full_d;
      data_q      <= data_d;
      count_out_q <= COUNT_W'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = {full_q, ok_q};
  assign m_axis_tdata  = {3'b000, count_out_q, data_q};

`ifndef NO_ASSERTIONS
  // the number of held cells equals the count
  a_count_matches_cells : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_v) == int'(count_q))
    else $error("cell held flags disagree with count");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("count exceeds depth");

  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op == OP_CLEAR) |=> (count_q == '0) && (valid_v == '0))
    else $error("clear left entries held");

  a_full_not_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
    else $error("refused add reported ok");

  a_add_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op == OP_ADD) && ok_d |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("accepted add did not grow the set");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_ordered_unique_set_table_unit.sv -----
// Self-checking testbench for ordered_unique_set_table_unit: a queued driver and
// a clocked monitor around an in-bench model of the ordered unique set.
// Depends on oust_pkg and the RTL of the block.
`default_nettype none

module tb_ordered_unique_set_table_unit;
  import oust_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned TAIL_ITEMS   = 100;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  typedef struct {
    bit                 drain;  // pause until every result is back
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
  } set_cmd_t;

  typedef struct packed {
    logic               ok;
    logic               full_res;
    logic [VALUE_W-1:0] data;
    logic [COUNT_W-1:0] count;
  } set_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;  // value[31:0], index[35:32], zero pad
  logic [2:0]  s_axis_tuser;  // cmd[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;  // data[31:0], count[36:32], zero pad
  logic [1:0]  m_axis_tuser;  // ok[0], full_res[1]

  ordered_unique_set_table_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  set_cmd_t           cmd_backlog[$];
  set_result_t        due_results[$];
  logic [VALUE_W-1:0] members[DEPTH_DEF];
  int                 held;
  int                 mismatches;
  int unsigned        cycles;
  int                 op_seen[8];
  int                 full_refusals;
  int                 peak_held;
  logic               in_fire;
  logic               tail_phase;
  int                 send_gap;
  int                 send_idle_pct;
  int                 take_stall;
  int                 take_idle_pct;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Set model: advances the membership list and gives the expected result.
  function automatic set_result_t apply_set_cmd(logic [CMD_W-1:0] cmd,
                                                logic [VALUE_W-1:0] value,
                                                logic [INDEX_W-1:0] index);
    set_result_t r;
    int          pos;
    r   = '0;
    pos = -1;
    for (int i = 0; i < held; i++) begin
      if (pos < 0 && members[i] == value) pos = i;
    end
    case (cmd)
      OP_ADD: begin
        // presence is tested before fullness
        if (pos < 0) begin
          if (held >= DEPTH_DEF) begin
            r.full_res = 1'b1;
          end else begin
            members[held] = value;
            held++;
            r.ok = 1'b1;
          end
        end
      end
      OP_CONTAINS: r.ok = (pos >= 0);
      OP_REMOVE: begin
        if (pos >= 0) begin
          for (int i = pos; i + 1 < held; i++) members[i] = members[i + 1];
          held--;
          r.ok = 1'b1;
        end
      end
      OP_GET: begin
        if (int'(index) < held) begin
          r.ok   = 1'b1;
          r.data = members[index];
        end
      end
      OP_CLEAR: held = 0;
      default: ;
    endcase
    r.count = COUNT_W'(held);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    mismatches++;
  endtask

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  // Monitor: check results against the oldest expectation, then predict
  // for the command item taken at this edge.
  always @(posedge clk_i) begin
    set_result_t want;
    set_result_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tuser[0], m_axis_tuser[1], m_axis_tdata[31:0], m_axis_tdata[36:32]};
        if (due_results.size() == 0) begin
          report_mismatch("result item with none expected, data", got.data, '0);
        end else begin
          want = due_results.pop_front();
          if (got.ok != want.ok)
            report_mismatch("ok", VALUE_W'(got.ok), VALUE_W'(want.ok));
          if (got.full_res != want.full_res)
            report_mismatch("full_res", VALUE_W'(got.full_res), VALUE_W'(want.full_res));
          if (got.data != want.data) report_mismatch("data", got.data, want.data);
          if (got.count != want.count)
            report_mismatch("count", VALUE_W'(got.count), VALUE_W'(want.count));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = apply_set_cmd(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[35:32]);
        due_results.push_back(want);
        op_seen[s_axis_tuser]++;
        if (want.full_res) full_refusals++;
        if (held > peak_held) peak_held = held;
      end
    end
    in_fire <= rst_ni && s_axis_tvalid && s_axis_tready;
  end

  // Driver: valid holds until the item is taken; new items come off the backlog.
  always @(negedge clk_i) begin
    set_cmd_t nxt;
    if (cycles % 64 == 0) send_idle_pct = pick_idle_pct();
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      tail_phase <= (cmd_backlog.size() <= TAIL_ITEMS);
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_backlog.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (cmd_backlog[0].drain) begin
        if (due_results.size() == 0) void'(cmd_backlog.pop_front());
        s_axis_tvalid <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 99) < send_idle_pct) begin
        send_gap = $urandom_range(0, 9);
        s_axis_tvalid <= 1'b0;
      end else begin
        nxt = cmd_backlog.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= nxt.cmd;
        s_axis_tdata  <= {4'b0, nxt.index, nxt.value};
      end
    end
  end

  // Receiver backpressure in bursts; none in the tail of the run.
  always @(negedge clk_i) begin
    if (cycles % 64 == 0) take_idle_pct = pick_idle_pct();
    if (!rst_ni || tail_phase) begin
      m_axis_tready <= 1'b1;
    end else if (take_stall > 0) begin
      take_stall--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < take_idle_pct) begin
      take_stall = $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               due_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                           input logic [INDEX_W-1:0] index);
    cmd_backlog.push_back('{1'b0, cmd, value, index});
  endtask

  task automatic queue_drain();
    cmd_backlog.push_back('{1'b1, OP_CLEAR, '0, '0});
  endtask

  initial begin
    logic [VALUE_W-1:0] pool[$];
    logic [VALUE_W-1:0] v;
    logic [CMD_W-1:0]   cmd;
    int                 made;
    int                 seg_len;
    int                 add_pct;
    int                 r;

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    rst_ni        = 1'b0;
    in_fire       = 1'b0;
    tail_phase    = 1'b0;
    held          = 0;
    mismatches    = 0;
    cycles        = 0;
    full_refusals = 0;
    peak_held     = 0;
    send_gap      = 0;
    take_stall    = 0;
    send_idle_pct = 0;
    take_idle_pct = 0;
    foreach (op_seen[i]) op_seen[i] = 0;

    // Directed: empty-set corner cases, fill to full, duplicate and refused
    // adds on a full table, remove with shift, spare command code.
    queue_cmd(OP_CONTAINS, '0, '0);
    queue_cmd(OP_REMOVE, '0, '0);
    queue_cmd(OP_GET, '0, '0);
    queue_cmd(OP_CLEAR, '1, '1);
    queue_cmd(OP_ADD, '0, '0);
    queue_cmd(OP_ADD, '1, '1);
    for (int i = 0; i < DEPTH_DEF - 2; i++) queue_cmd(OP_ADD, 32'h1 << (2 * i + 1), '0);
    queue_cmd(OP_ADD, '1, '0);
    queue_cmd(OP_ADD, 32'h1234_5678, '0);
    queue_cmd(OP_GET, '0, '1);
    queue_cmd(OP_REMOVE, '0, '0);
    queue_cmd(OP_GET, '0, '0);
    queue_cmd(CMD_SPARE_FIRST, '1, '1);
    queue_cmd(OP_CLEAR, '0, '0);
    queue_drain();

    // Random: segments over a small pool of values so that adds, lookups and
    // removes keep hitting held entries; the add rate varies to reach full.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      pool.delete();
      r = $urandom_range(4, 24);
      for (int i = 0; i < r; i++) pool.push_back($urandom());
      if ($urandom_range(0, 1)) pool.push_back('0);
      if ($urandom_range(0, 1)) pool.push_back('1);
      seg_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0:       add_pct = 25;
        1:       add_pct = 40;
        default: add_pct = 70;
      endcase
      for (int k = 0; k < seg_len && made < RANDOM_ITEMS; k++) begin
        v = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, pool.size() - 1)]
                                         : $urandom();
        r = $urandom_range(0, 99);
        if (r < add_pct) cmd = OP_ADD;
        else if (r < add_pct + (100 - add_pct) * 25 / 100) cmd = OP_CONTAINS;
        else if (r < add_pct + (100 - add_pct) * 50 / 100) cmd = OP_REMOVE;
        else if (r < 95) cmd = OP_GET;
        else if (r < 97) cmd = OP_CLEAR;
        else cmd = CMD_SPARE_LAST - 3'($urandom_range(0, 2));
        queue_cmd(cmd, v, INDEX_W'($urandom_range(0, 15)));
        made++;
      end
      if ($urandom_range(0, 5) == 0) queue_drain();
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_backlog.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("commands: add %0d, contains %0d, remove %0d, get %0d, clear %0d, spare %0d",
             op_seen[OP_ADD], op_seen[OP_CONTAINS], op_seen[OP_REMOVE], op_seen[OP_GET],
             op_seen[OP_CLEAR], op_seen[5] + op_seen[6] + op_seen[7]);
    $display("adds refused on a full table: %0d, highest fill: %0d, mismatches: %0d",
             full_refusals, peak_held, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
